/* design/ttrrs_pkg.sv */
// Types and constants shared by the thread table scheduler.
`default_nettype none
package ttrrs_pkg;

	localparam int THREAD_SLOTS_DEF = 16;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_YIELD  = 2'd1,
		OP_EXIT   = 2'd2,
		OP_JOIN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_UNUSED     = 2'd0,
		ST_RUNNABLE   = 2'd1,
		ST_WAITING    = 2'd2,
		ST_TERMINATED = 2'd3
	} slot_st_t;

	typedef enum logic [1:0] {
		RS_OK   = 2'd0,
		RS_FULL = 2'd1,
		RS_NONE = 2'd2
	} res_st_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_CREATE,
		SQ_JOIN_CHK,
		SQ_YIELD,
		SQ_TGT_RD,
		SQ_TGT_CHK,
		SQ_DONE
	} seq_st_t;

	typedef struct packed {
		op_t        operation;
		logic [3:0] target_slot;
	} req_t;

	typedef struct packed {
		res_st_t    status;
		logic [3:0] running_slot;
		logic [3:0] created_slot;
		logic       switched;
	} rsp_t;

	typedef struct packed {
		logic       rd_en;
		logic       wr_en;
		slot_st_t   wr_status;
		logic       wr_jt_en;
		logic [3:0] wr_jt;
	} mem_ctl_t;

endpackage
`default_nettype wire

/* design/thread_table_round_robin_scheduler.sv */
// Top level of the thread table round robin scheduler.
//
// One request channel (req, req_valid, req_stall) carries an operation and a
// join target; one response channel (rsp, rsp_valid, rsp_stall) returns one
// response per request: status, running slot, created slot and switch flag.
// A request is taken only while the sequencer is idle; req_stall is high for
// the whole of an operation.
// Create scans for an unused slot; yield and exit scan for the next runnable
// slot, checking the join target of each waiting slot they meet; join first
// looks up its target, and returns at once when the target is unused,
// terminated or out of range. The slot table has a single read port: the scan
// looks at one slot per cycle, pausing while a waiting slot's target is read.
// The response sits in an output register; the next request is taken while
// it waits. If the receiver stalls and a second response is ready, the
// sequencer holds it and req_stall stays high until the register frees.
// After reset slot 0 is the running thread, every other slot is unused and
// both channels are empty; no clearing pass is needed.
`default_nettype none
module thread_table_round_robin_scheduler #(
	parameter int THREAD_SLOTS = ttrrs_pkg::THREAD_SLOTS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire ttrrs_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output ttrrs_pkg::rsp_t      rsp
);

	localparam int SW = $clog2(THREAD_SLOTS);

	ttrrs_pkg::mem_ctl_t  ctl;
	ttrrs_pkg::slot_st_t  rd_status;
	ttrrs_pkg::rsp_t      res;
	logic [SW-1:0]        rd_addr;
	logic [SW-1:0]        wr_addr;
	logic [3:0]           rd_jt;
	logic                 rd_vld;
	logic                 ready;
	logic                 done;
	logic                 take;
	logic                 rsp_valid_q;
	ttrrs_pkg::rsp_t      rsp_q;

	assign req_stall = !ready;
	assign take      = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (take && done) begin
			rsp_q <= res;
		end
	end

	ttrrs_seq #(
		.THREAD_SLOTS(THREAD_SLOTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.ready     (ready),
		.done      (done),
		.take      (take),
		.res       (res),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.rd_vld    (rd_vld),
		.rd_status (rd_status),
		.rd_jt     (rd_jt)
	);

	ttrrs_slot_mem #(
		.THREAD_SLOTS(THREAD_SLOTS)
	) u_slot_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.rd_vld    (rd_vld),
		.rd_status (rd_status),
		.rd_jt     (rd_jt)
	);

endmodule
`default_nettype wire

/* design/ttrrs_slot_mem.sv */
// Slot table: status and join target per slot, one read and one write port.
`default_nettype none
module ttrrs_slot_mem #(
	parameter int THREAD_SLOTS = ttrrs_pkg::THREAD_SLOTS_DEF,
	localparam int SW = $clog2(THREAD_SLOTS)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ttrrs_pkg::mem_ctl_t ctl,
	input  wire logic [SW-1:0]       rd_addr,
	input  wire logic [SW-1:0]       wr_addr,
	output logic                     rd_vld,
	output ttrrs_pkg::slot_st_t      rd_status,
	output logic [3:0]               rd_jt
);

	ttrrs_pkg::slot_st_t status_mem [THREAD_SLOTS];
	logic [3:0]          jt_mem [THREAD_SLOTS];
	logic [THREAD_SLOTS-1:0] ent_vld_q;

	ttrrs_pkg::slot_st_t status_s1;
	logic                ent_vld_s1;
	logic                addr0_s1;
	logic                rd_vld_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			status_mem[wr_addr] <= ctl.wr_status;
		end
		if (ctl.wr_jt_en) begin
			jt_mem[wr_addr] <= ctl.wr_jt;
		end
		if (ctl.rd_en) begin
			status_s1 <= status_mem[rd_addr];
			rd_jt     <= jt_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q  <= '0;
			rd_vld_s1  <= 1'b0;
			ent_vld_s1 <= 1'b0;
			addr0_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.rd_en;
			if (ctl.wr_en) begin
				ent_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				ent_vld_s1 <= ent_vld_q[rd_addr];
				addr0_s1   <= (rd_addr == '0);
			end
		end
	end

	// a status entry not yet written reads as its reset state: slot 0 runnable, others unused
	always_comb begin
		rd_vld = rd_vld_s1;
		if (ent_vld_s1) begin
			rd_status = status_s1;
		end else if (addr0_s1) begin
			rd_status = ttrrs_pkg::ST_RUNNABLE;
		end else begin
			rd_status = ttrrs_pkg::ST_UNUSED;
		end
	end

endmodule
`default_nettype wire

/* design/ttrrs_seq.sv */
// Sequencer: walks the slot table one slot per cycle for create, yield, exit and join, pausing for join target checks.
`default_nettype none
module ttrrs_seq #(
	parameter int THREAD_SLOTS = ttrrs_pkg::THREAD_SLOTS_DEF,
	localparam int SW = $clog2(THREAD_SLOTS),
	localparam int CW = $clog2(THREAD_SLOTS + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire ttrrs_pkg::req_t     req,
	output logic                     ready,
	output logic                     done,
	input  wire logic                take,
	output ttrrs_pkg::rsp_t          res,
	output ttrrs_pkg::mem_ctl_t      ctl,
	output logic [SW-1:0]            rd_addr,
	output logic [SW-1:0]            wr_addr,
	input  wire logic                rd_vld,
	input  wire ttrrs_pkg::slot_st_t rd_status,
	input  wire logic [3:0]          rd_jt
);

	ttrrs_pkg::seq_st_t state_q, state_d;
	logic [SW-1:0] cur_q, cur_d;
	logic [SW-1:0] iss_idx_q, iss_idx_d;
	logic [CW-1:0] iss_cnt_q, iss_cnt_d;
	logic [SW-1:0] last_addr_q;
	logic [SW-1:0] wait_idx_q, wait_idx_d;
	logic [3:0]    wait_jt_q, wait_jt_d;
	logic [3:0]    tgt_q, tgt_d;
	ttrrs_pkg::rsp_t res_q, res_d;
	logic          tgt_in_range;
	logic          scan_hit;

	function automatic logic [SW-1:0] nxt(input logic [SW-1:0] x);
		logic [SW-1:0] r;
		if (x == SW'(THREAD_SLOTS - 1)) begin
			r = '0;
		end else begin
			r = x + SW'(1);
		end
		return r;
	endfunction

	function automatic logic [3:0] to_nib(input logic [SW-1:0] x);
		logic [SW+3:0] e;
		e = {4'b0, x};
		return e[3:0];
	endfunction

	function automatic logic [SW-1:0] to_slot(input logic [3:0] t);
		logic [SW+3:0] e;
		e = {{SW{1'b0}}, t};
		return e[SW-1:0];
	endfunction

	assign tgt_in_range = {28'd0, req.target_slot} < 32'(THREAD_SLOTS);
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttrrs_pkg::SQ_IDLE;
			cur_q   <= '0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		iss_idx_q  <= iss_idx_d;
		iss_cnt_q  <= iss_cnt_d;
		wait_idx_q <= wait_idx_d;
		wait_jt_q  <= wait_jt_d;
		tgt_q      <= tgt_d;
		res_q      <= res_d;
		if (ctl.rd_en) begin
			last_addr_q <= rd_addr;
		end
	end

	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		iss_idx_d  = iss_idx_q;
		iss_cnt_d  = iss_cnt_q;
		wait_idx_d = wait_idx_q;
		wait_jt_d  = wait_jt_q;
		tgt_d      = tgt_q;
		res_d      = res_q;
		ready      = 1'b0;
		done       = 1'b0;
		ctl        = '0;
		rd_addr    = iss_idx_q;
		wr_addr    = cur_q;
		scan_hit   = 1'b0;

		case (state_q)
			ttrrs_pkg::SQ_IDLE: begin
				ready = 1'b1;
				res_d.status       = ttrrs_pkg::RS_OK;
				res_d.running_slot = to_nib(cur_q);
				res_d.created_slot = 4'd0;
				res_d.switched     = 1'b0;
				iss_idx_d = nxt(cur_q);
				iss_cnt_d = '0;
				tgt_d     = req.target_slot;
				if (req_valid) begin
					case (req.operation)
						ttrrs_pkg::OP_CREATE: begin
							iss_idx_d = SW'(1);
							state_d   = ttrrs_pkg::SQ_CREATE;
						end
						ttrrs_pkg::OP_YIELD: begin
							state_d = ttrrs_pkg::SQ_YIELD;
						end
						ttrrs_pkg::OP_EXIT: begin
							ctl.wr_en     = 1'b1;
							ctl.wr_status = ttrrs_pkg::ST_TERMINATED;
							state_d       = ttrrs_pkg::SQ_YIELD;
						end
						ttrrs_pkg::OP_JOIN: begin
							if (tgt_in_range) begin
								ctl.rd_en = 1'b1;
								rd_addr   = to_slot(req.target_slot);
								state_d   = ttrrs_pkg::SQ_JOIN_CHK;
							end else begin
								state_d = ttrrs_pkg::SQ_DONE;
							end
						end
						default: begin
							state_d = ttrrs_pkg::SQ_DONE;
						end
					endcase
				end
			end

			ttrrs_pkg::SQ_CREATE: begin
				if (rd_vld && rd_status == ttrrs_pkg::ST_UNUSED) begin
					ctl.wr_en          = 1'b1;
					ctl.wr_status      = ttrrs_pkg::ST_RUNNABLE;
					ctl.wr_jt_en       = 1'b1;
					ctl.wr_jt          = 4'd0;
					wr_addr            = last_addr_q;
					res_d.created_slot = to_nib(last_addr_q);
					state_d            = ttrrs_pkg::SQ_DONE;
				end else if (iss_cnt_q != CW'(THREAD_SLOTS - 1)) begin
					ctl.rd_en = 1'b1;
					iss_idx_d = nxt(iss_idx_q);
					iss_cnt_d = iss_cnt_q + CW'(1);
				end else if (!rd_vld) begin
					res_d.status = ttrrs_pkg::RS_FULL;
					state_d      = ttrrs_pkg::SQ_DONE;
				end
			end

			ttrrs_pkg::SQ_JOIN_CHK: begin
				if (rd_status == ttrrs_pkg::ST_UNUSED ||
				    rd_status == ttrrs_pkg::ST_TERMINATED) begin
					state_d = ttrrs_pkg::SQ_DONE;
				end else begin
					ctl.wr_en     = 1'b1;
					ctl.wr_status = ttrrs_pkg::ST_WAITING;
					ctl.wr_jt_en  = 1'b1;
					ctl.wr_jt     = tgt_q;
					state_d       = ttrrs_pkg::SQ_YIELD;
				end
			end

			ttrrs_pkg::SQ_YIELD: begin
				if (rd_vld && rd_status == ttrrs_pkg::ST_RUNNABLE) begin
					scan_hit           = 1'b1;
					cur_d              = last_addr_q;
					res_d.running_slot = to_nib(last_addr_q);
					res_d.switched     = (last_addr_q != cur_q);
					state_d            = ttrrs_pkg::SQ_DONE;
				end else if (rd_vld && rd_status == ttrrs_pkg::ST_WAITING) begin
					scan_hit   = 1'b1;
					wait_idx_d = last_addr_q;
					wait_jt_d  = rd_jt;
					state_d    = ttrrs_pkg::SQ_TGT_RD;
				end
				if (!scan_hit) begin
					if (iss_cnt_q != CW'(THREAD_SLOTS)) begin
						ctl.rd_en = 1'b1;
						iss_idx_d = nxt(iss_idx_q);
						iss_cnt_d = iss_cnt_q + CW'(1);
					end else if (!rd_vld) begin
						res_d.status = ttrrs_pkg::RS_NONE;
						state_d      = ttrrs_pkg::SQ_DONE;
					end
				end
			end

			ttrrs_pkg::SQ_TGT_RD: begin
				ctl.rd_en = 1'b1;
				rd_addr   = to_slot(wait_jt_q);
				state_d   = ttrrs_pkg::SQ_TGT_CHK;
			end

			ttrrs_pkg::SQ_TGT_CHK: begin
				if (rd_status == ttrrs_pkg::ST_TERMINATED) begin
					ctl.wr_en          = 1'b1;
					ctl.wr_status      = ttrrs_pkg::ST_RUNNABLE;
					wr_addr            = wait_idx_q;
					cur_d              = wait_idx_q;
					res_d.running_slot = to_nib(wait_idx_q);
					res_d.switched     = (wait_idx_q != cur_q);
					state_d            = ttrrs_pkg::SQ_DONE;
				end else begin
					state_d = ttrrs_pkg::SQ_YIELD;
				end
			end

			ttrrs_pkg::SQ_DONE: begin
				done = 1'b1;
				if (take) begin
					state_d = ttrrs_pkg::SQ_IDLE;
				end
			end

			default: begin
				state_d = ttrrs_pkg::SQ_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the thread table round robin scheduler.
`timescale 1ns / 1ps
module tb;
	import ttrrs_pkg::*;

	localparam int SLOTS = THREAD_SLOTS_DEF;
	localparam int N_RANDOM = 1880;
	localparam int N_QUIET = 150;
	localparam int LONG_HOLD = 400;
	localparam int LIMIT = 1000000;

	class sched_scoreboard;
		slot_st_t   slot_state [SLOTS];
		logic [3:0] waits_on [SLOTS];
		logic [3:0] running;
		rsp_t       outcome_q [$];
		res_st_t    last_status;
		int         mismatches;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				slot_state[i] = ST_UNUSED;
				waits_on[i] = '0;
			end
			slot_state[0] = ST_RUNNABLE;
			running = '0;
			last_status = RS_OK;
			mismatches = 0;
		endfunction

		function bit rotate_to_ready();
			logic [3:0] idx;
			for (int j = 1; j <= SLOTS; j++) begin
				idx = running + j[3:0];
				if (slot_state[idx] == ST_RUNNABLE) begin
					running = idx;
					return 1'b1;
				end
				if (slot_state[idx] == ST_WAITING &&
				    slot_state[waits_on[idx]] == ST_TERMINATED) begin
					slot_state[idx] = ST_RUNNABLE;
					running = idx;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(req_t item);
			rsp_t       o;
			logic [3:0] prior;
			bit         yield_now;
			o = '0;
			o.status = RS_OK;
			prior = running;
			yield_now = 1'b0;
			case (item.operation)
				OP_CREATE: begin
					o.status = RS_FULL;
					for (int i = 1; i < SLOTS; i++) begin
						if (slot_state[i] == ST_UNUSED) begin
							slot_state[i] = ST_RUNNABLE;
							waits_on[i] = '0;
							o.created_slot = i[3:0];
							o.status = RS_OK;
							break;
						end
					end
				end
				OP_YIELD: yield_now = 1'b1;
				OP_EXIT: begin
					slot_state[running] = ST_TERMINATED;
					yield_now = 1'b1;
				end
				default: begin
					if (slot_state[item.target_slot] != ST_UNUSED &&
					    slot_state[item.target_slot] != ST_TERMINATED) begin
						slot_state[running] = ST_WAITING;
						waits_on[running] = item.target_slot;
						yield_now = 1'b1;
					end
				end
			endcase
			if (yield_now && !rotate_to_ready())
				o.status = RS_NONE;
			o.running_slot = running;
			o.switched = (running != prior);
			last_status = o.status;
			outcome_q.push_back(o);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected response %p", $time, got);
				return;
			end
			want = outcome_q.pop_front();
			if (got.status !== want.status || got.running_slot !== want.running_slot ||
			    got.created_slot !== want.created_slot || got.switched !== want.switched) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch expected %p got %p", $time, want, got);
			end
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		function logic [3:0] live_other();
			logic [3:0] picks [$];
			for (int i = 0; i < SLOTS; i++)
				if (i[3:0] != running &&
				    (slot_state[i] == ST_RUNNABLE || slot_state[i] == ST_WAITING))
					picks.push_back(i[3:0]);
			if (picks.size() == 0)
				return 4'($urandom_range(0, 15));
			return picks[$urandom_range(0, picks.size() - 1)];
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b1;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	sched_scoreboard sched = new();
	bit quiet = 1'b0;
	bit long_hold_pending = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	thread_table_round_robin_scheduler #(.THREAD_SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && !rsp_stall)
			sched.check_response(rsp);
		if (long_hold_pending) begin
			long_hold_pending = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < 12) begin
			hold_left = $urandom_range(0, 5);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_item(op_t op, logic [3:0] tgt);
		req_t item;
		item.operation = op;
		item.target_slot = tgt;
		if (!quiet && $urandom_range(0, 99) < 15) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sched.note_request(item);
	endtask

	initial begin
		int         r;
		int         exit_th;
		op_t        op;
		logic [3:0] tgt;

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_YIELD, 4'd0);
		send_item(OP_JOIN, 4'd7);
		send_item(OP_CREATE, 4'd0);
		send_item(OP_YIELD, 4'd0);
		send_item(OP_JOIN, 4'd1);
		send_item(OP_JOIN, 4'd1);
		send_item(OP_YIELD, 4'd0);
		send_item(OP_CREATE, 4'd0);
		send_item(OP_YIELD, 4'd0);
		send_item(OP_EXIT, 4'd0);
		send_item(OP_JOIN, 4'd2);
		send_item(OP_CREATE, 4'd0);
		send_item(OP_CREATE, 4'd0);
		send_item(OP_YIELD, 4'd0);
		send_item(OP_JOIN, 4'd4);
		send_item(OP_EXIT, 4'd0);
		repeat (12) send_item(OP_CREATE, 4'($urandom_range(0, 15)));

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - N_QUIET)
				quiet = 1'b1;
			if (i == 600)
				long_hold_pending = 1'b1;
			if (i == 1200) begin
				req_valid <= 1'b0;
				while (sched.pending() != 0) @(posedge clk);
			end
			r = $urandom_range(0, 999);
			exit_th = (sched.last_status == RS_NONE) ? 300 : 12;
			if (r < exit_th)
				op = OP_EXIT;
			else if (r < exit_th + 60)
				op = OP_CREATE;
			else if (r < 800)
				op = OP_YIELD;
			else
				op = OP_JOIN;
			if (op == OP_JOIN && $urandom_range(0, 2) != 0)
				tgt = sched.live_other();
			else
				tgt = 4'($urandom_range(0, 15));
			send_item(op, tgt);
		end

		req_valid <= 1'b0;
		while (sched.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sched.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

/* sim.f */
design/ttrrs_pkg.sv
design/ttrrs_slot_mem.sv
design/ttrrs_seq.sv
design/thread_table_round_robin_scheduler.sv
tb/sv/tb.sv
